// ===== src/adc_ladder_keypad_debouncer_top_defines.svh =====
// Assertion macros shared by the keypad debouncer RTL.
// Every macro expects clk and rst_n to be visible where it is used.
`ifndef ADC_LADDER_KEYPAD_DEBOUNCER_TOP_DEFINES_SVH
`define ADC_LADDER_KEYPAD_DEBOUNCER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset only.
`define ALKD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset only.
`define ALKD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/alkd_pkg.sv =====
// Shared constants and types of the ladder keypad debouncer.
// No dependencies; the design files other than the macro header refer to it by scoped names.
package alkd_pkg;

    localparam int NUM_KEYS     = 7;
    localparam int NUM_LEVELS_A = 4;
    localparam int NUM_LEVELS_B = 2;
    localparam int SAMPLE_W     = 12;
    localparam int TIME_W       = 32;
    localparam int DEBOUNCE_W   = 16;
    localparam int KEY_IDX_W    = 3;
    localparam int REG_IDX_W    = 3;
    localparam int REG_DATA_W   = 16;

    localparam logic [SAMPLE_W-1:0] NO_KEY_LEVEL = 12'd3800;
    localparam int POWER_KEY = 6;
    localparam int LADDER_B_BASE = 4;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_LADDER_A_LEVEL0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LADDER_A_LEVEL1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LADDER_A_LEVEL2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LADDER_A_LEVEL3 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LADDER_B_LEVEL0 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LADDER_B_LEVEL1 = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_MATCH_TOLERANCE = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE_MS     = 3'd7;

    // Reset values
    localparam logic [SAMPLE_W-1:0]   RST_LADDER_A_LEVEL0 = 12'd3470;
    localparam logic [SAMPLE_W-1:0]   RST_LADDER_A_LEVEL1 = 12'd2655;
    localparam logic [SAMPLE_W-1:0]   RST_LADDER_A_LEVEL2 = 12'd1470;
    localparam logic [SAMPLE_W-1:0]   RST_LADDER_A_LEVEL3 = 12'd3;
    localparam logic [SAMPLE_W-1:0]   RST_LADDER_B_LEVEL0 = 12'd2205;
    localparam logic [SAMPLE_W-1:0]   RST_LADDER_B_LEVEL1 = 12'd3;
    localparam logic [SAMPLE_W-1:0]   RST_MATCH_TOLERANCE = 12'd100;
    localparam logic [DEBOUNCE_W-1:0] RST_DEBOUNCE_MS     = 16'd5;

    typedef logic [NUM_KEYS-1:0] key_mask_t;

    typedef struct packed {
        logic [NUM_LEVELS_A-1:0][SAMPLE_W-1:0] level_a;
        logic [NUM_LEVELS_B-1:0][SAMPLE_W-1:0] level_b;
        logic [SAMPLE_W-1:0]                   tolerance;
        logic [DEBOUNCE_W-1:0]                 debounce_ms;
    } cfg_t;

    // Classified sample handed from the front end to the debounce back end
    typedef struct packed {
        key_mask_t            raw_mask;
        logic [TIME_W-1:0]    now_ms;
        logic [KEY_IDX_W-1:0] hold_key;
    } key_item_t;

endpackage

// ===== src/alkd_if.sv =====
// Valid/ready channel interfaces for samples and results of the keypad debouncer.
// Depends on alkd_pkg for field widths.
interface alkd_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic [alkd_pkg::SAMPLE_W-1:0]        sample_a;
    logic [alkd_pkg::SAMPLE_W-1:0]        sample_b;
    logic                                 power_pin;
    logic [alkd_pkg::TIME_W-1:0]          now_ms;
    logic [alkd_pkg::KEY_IDX_W-1:0]       hold_key;

    modport source (output valid, sample_a, sample_b, power_pin, now_ms, hold_key,
                    input ready);
    modport sink   (input valid, sample_a, sample_b, power_pin, now_ms, hold_key,
                    output ready);
endinterface

interface alkd_result_if;
    logic                          valid;
    logic                          ready;
    logic [alkd_pkg::NUM_KEYS-1:0] held_mask;
    logic [alkd_pkg::NUM_KEYS-1:0] pressed_mask;
    logic [alkd_pkg::NUM_KEYS-1:0] released_mask;
    logic [alkd_pkg::NUM_KEYS-1:0] raw_mask;
    logic [alkd_pkg::TIME_W-1:0]   hold_ms;

    modport source (output valid, held_mask, pressed_mask, released_mask, raw_mask,
                    hold_ms, input ready);
    modport sink   (input valid, held_mask, pressed_mask, released_mask, raw_mask,
                    hold_ms, output ready);
endinterface

// ===== src/alkd_cfg_regs.sv =====
// Configuration register file: ladder levels, match tolerance, debounce delay.
// Depends on alkd_pkg.
module alkd_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [alkd_pkg::REG_IDX_W-1:0]     wr_index,
    input  logic [alkd_pkg::REG_DATA_W-1:0]    wr_data,
    output alkd_pkg::cfg_t                     cfg
);

    alkd_pkg::cfg_t cfg_reg;
    alkd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                alkd_pkg::REG_LADDER_A_LEVEL0: cfg_next.level_a[0] = wr_data[11:0];
                alkd_pkg::REG_LADDER_A_LEVEL1: cfg_next.level_a[1] = wr_data[11:0];
                alkd_pkg::REG_LADDER_A_LEVEL2: cfg_next.level_a[2] = wr_data[11:0];
                alkd_pkg::REG_LADDER_A_LEVEL3: cfg_next.level_a[3] = wr_data[11:0];
                alkd_pkg::REG_LADDER_B_LEVEL0: cfg_next.level_b[0] = wr_data[11:0];
                alkd_pkg::REG_LADDER_B_LEVEL1: cfg_next.level_b[1] = wr_data[11:0];
                alkd_pkg::REG_MATCH_TOLERANCE: cfg_next.tolerance  = wr_data[11:0];
                alkd_pkg::REG_DEBOUNCE_MS:     cfg_next.debounce_ms = wr_data;
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.level_a[0]  <= alkd_pkg::RST_LADDER_A_LEVEL0;
            cfg_reg.level_a[1]  <= alkd_pkg::RST_LADDER_A_LEVEL1;
            cfg_reg.level_a[2]  <= alkd_pkg::RST_LADDER_A_LEVEL2;
            cfg_reg.level_a[3]  <= alkd_pkg::RST_LADDER_A_LEVEL3;
            cfg_reg.level_b[0]  <= alkd_pkg::RST_LADDER_B_LEVEL0;
            cfg_reg.level_b[1]  <= alkd_pkg::RST_LADDER_B_LEVEL1;
            cfg_reg.tolerance   <= alkd_pkg::RST_MATCH_TOLERANCE;
            cfg_reg.debounce_ms <= alkd_pkg::RST_DEBOUNCE_MS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/alkd_front.sv =====
// Front end: accepts sample beats and decodes the ladders into a raw key mask.
// Depends on alkd_pkg and alkd_sample_if.
module alkd_front (
    input  logic                   clk,
    input  logic                   rst_n,
    alkd_sample_if.sink            samples,
    input  alkd_pkg::cfg_t         cfg,
    output logic                   item_valid,
    input  logic                   item_ready,
    output alkd_pkg::key_item_t    item
);

    logic                  valid_reg;
    logic                  valid_next;
    alkd_pkg::key_item_t   item_reg;
    alkd_pkg::key_item_t   item_next;
    logic                  take;

    function automatic logic level_match(
        input logic [alkd_pkg::SAMPLE_W-1:0] sample,
        input logic [alkd_pkg::SAMPLE_W-1:0] level,
        input logic [alkd_pkg::SAMPLE_W-1:0] tol
    );
        logic [alkd_pkg::SAMPLE_W-1:0] gap;
        begin
            gap = (sample > level) ? (sample - level) : (level - sample);
            level_match = gap < tol;
        end
    endfunction

    assign take          = samples.valid && samples.ready;
    assign samples.ready = !valid_reg || item_ready;

    always_comb
    begin
        logic hit_a;
        logic hit_b;
        hit_a = 1'b0;
        hit_b = 1'b0;
        item_next.raw_mask = '0;
        // First matching level of each ladder wins
        if (samples.sample_a <= alkd_pkg::NO_KEY_LEVEL)
        begin
            for (int i = 0; i < alkd_pkg::NUM_LEVELS_A; i++)
            begin
                if (!hit_a && level_match(samples.sample_a, cfg.level_a[i], cfg.tolerance))
                begin
                    item_next.raw_mask[i] = 1'b1;
                    hit_a = 1'b1;
                end
            end
        end
        if (samples.sample_b <= alkd_pkg::NO_KEY_LEVEL)
        begin
            for (int i = 0; i < alkd_pkg::NUM_LEVELS_B; i++)
            begin
                if (!hit_b && level_match(samples.sample_b, cfg.level_b[i], cfg.tolerance))
                begin
                    item_next.raw_mask[alkd_pkg::LADDER_B_BASE + i] = 1'b1;
                    hit_b = 1'b1;
                end
            end
        end
        item_next.raw_mask[alkd_pkg::POWER_KEY] = !samples.power_pin;
        item_next.now_ms   = samples.now_ms;
        item_next.hold_key = samples.hold_key;
    end

    assign valid_next = take ? 1'b1 : (item_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== src/alkd_fifo.sv =====
// Two-entry queue decoupling the decode front end from the debounce back end.
// Depends on alkd_pkg and the assertion macro header.
`include "adc_ladder_keypad_debouncer_top_defines.svh"

module alkd_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push_valid,
    output logic                   push_ready,
    input  alkd_pkg::key_item_t    push_item,
    output logic                   pop_valid,
    input  logic                   pop_ready,
    output alkd_pkg::key_item_t    pop_item
);

    alkd_pkg::key_item_t   mem [2];
    logic                  wr_ptr_reg;
    logic                  wr_ptr_next;
    logic                  rd_ptr_reg;
    logic                  rd_ptr_next;
    logic [1:0]            count_reg;
    logic [1:0]            count_next;
    logic                  push;
    logic                  pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    `ALKD_ASSERT_NOW(a_fifo_count_bound, 1'b1, count_reg != 2'd3, "fifo count out of range")
    `ALKD_ASSERT_NOW(a_fifo_ptr_sync, count_reg == 2'd0 || count_reg == 2'd2,
        wr_ptr_reg == rd_ptr_reg, "fifo pointers disagree with count")

endmodule

// ===== src/alkd_back.sv =====
// Back end: per-key debounce state, timers and the registered result beat.
// Depends on alkd_pkg, alkd_result_if and the assertion macro header.
`include "adc_ladder_keypad_debouncer_top_defines.svh"

module alkd_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  alkd_pkg::cfg_t         cfg,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  alkd_pkg::key_item_t    item,
    alkd_result_if.source          results
);

    alkd_pkg::key_mask_t           held_reg;
    alkd_pkg::key_mask_t           held_next;
    alkd_pkg::key_mask_t           last_raw_reg;
    logic [alkd_pkg::TIME_W-1:0]   stamp_reg [alkd_pkg::NUM_KEYS];
    logic [alkd_pkg::TIME_W-1:0]   stamp_next [alkd_pkg::NUM_KEYS];
    alkd_pkg::key_mask_t           changed;
    logic [alkd_pkg::TIME_W-1:0]   diff [alkd_pkg::NUM_KEYS];
    logic [alkd_pkg::TIME_W-1:0]   hold_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    alkd_pkg::key_mask_t           out_held_reg;
    alkd_pkg::key_mask_t           out_pressed_reg;
    alkd_pkg::key_mask_t           out_released_reg;
    alkd_pkg::key_mask_t           out_raw_reg;
    logic [alkd_pkg::TIME_W-1:0]   out_hold_reg;
    logic                          step;

    assign item_ready = !out_valid_reg || results.ready;
    assign step       = item_valid && item_ready;

    always_comb
    begin
        hold_next = '0;
        for (int i = 0; i < alkd_pkg::NUM_KEYS; i++)
        begin
            changed[i]    = item.raw_mask[i] != last_raw_reg[i];
            diff[i]       = item.now_ms - stamp_reg[i];
            stamp_next[i] = changed[i] ? item.now_ms : stamp_reg[i];
            // Release at once; press only once the unchanged level has outlived the delay
            if (item.raw_mask[i])
            begin
                held_next[i] = held_reg[i] ||
                    (!changed[i] && diff[i] > {16'd0, cfg.debounce_ms});
            end
            else
            begin
                held_next[i] = 1'b0;
            end
        end
        for (int i = 0; i < alkd_pkg::NUM_KEYS; i++)
        begin
            if (item.hold_key == alkd_pkg::KEY_IDX_W'(i) && held_next[i] && !changed[i])
            begin
                hold_next = diff[i];
            end
        end
    end

    assign out_valid_next = step ? 1'b1 : (results.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            last_raw_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < alkd_pkg::NUM_KEYS; i++)
            begin
                stamp_reg[i] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (step)
            begin
                held_reg     <= held_next;
                last_raw_reg <= item.raw_mask;
                for (int i = 0; i < alkd_pkg::NUM_KEYS; i++)
                begin
                    stamp_reg[i] <= stamp_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_held_reg     <= held_next;
            out_pressed_reg  <= held_next & ~held_reg;
            out_released_reg <= ~held_next & held_reg;
            out_raw_reg      <= item.raw_mask;
            out_hold_reg     <= hold_next;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.held_mask     = out_held_reg;
    assign results.pressed_mask  = out_pressed_reg;
    assign results.released_mask = out_released_reg;
    assign results.raw_mask      = out_raw_reg;
    assign results.hold_ms       = out_hold_reg;

    `ALKD_ASSERT_NEXT(a_back_held_tracks, step, results.held_mask == held_reg,
        "result held mask differs from debounce state")
    `ALKD_ASSERT_NOW(a_back_edges_in_held, results.valid,
        (results.pressed_mask & ~results.held_mask) == '0 &&
        (results.released_mask & results.held_mask) == '0,
        "edge masks inconsistent with held mask")
    `ALKD_ASSERT_NOW(a_back_held_is_raw, results.valid,
        (results.held_mask & ~results.raw_mask) == '0,
        "key held without a raw press")
    `ALKD_ASSERT_NEXT(a_back_raw_tracks, step, last_raw_reg == results.raw_mask,
        "last raw state differs from delivered raw mask")

endmodule

// ===== src/adc_ladder_keypad_debouncer_top.sv =====
// Resistor-ladder keypad decoder with per-key debounce, seven keys.
//
// Channels: samples (sink) carries sample_a, sample_b, power_pin, now_ms and
// hold_key; results (source) carries held_mask, pressed_mask, released_mask,
// raw_mask and hold_ms, one result beat for every sample beat, in order.
// Registers are written through wr_en / wr_index / wr_data; the user must do so
// only while the block is idle; the block does not enforce it. Index 0-5 ladder
// levels, 6 match tolerance, 7 debounce delay. Throughput: one beat per cycle
// while results is ready; the seven key checks and timer differences run side
// by side in the back end. An accepted sample reaches its result through the
// decode register, the two-entry queue and the result register.
// When results stalls, the result register holds, the queue fills and the
// decode register holds; up to four beats are absorbed before samples.ready
// drops. Reset clears the key states and timers, empties the pipeline and
// loads the register reset values; samples are accepted right after reset.
// Depends on alkd_pkg, alkd_if and the alkd_* modules.
module adc_ladder_keypad_debouncer_top (
    input  logic                               clk,
    input  logic                               rst_n,
    alkd_sample_if.sink                        samples,
    alkd_result_if.source                      results,
    input  logic                               wr_en,
    input  logic [alkd_pkg::REG_IDX_W-1:0]     wr_index,
    input  logic [alkd_pkg::REG_DATA_W-1:0]    wr_data
);

    alkd_pkg::cfg_t        cfg;
    logic                  front_valid;
    logic                  front_ready;
    alkd_pkg::key_item_t   front_item;
    logic                  queue_valid;
    logic                  queue_ready;
    alkd_pkg::key_item_t   queue_item;

    alkd_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    alkd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .cfg        (cfg),
        .item_valid (front_valid),
        .item_ready (front_ready),
        .item       (front_item)
    );

    alkd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_item   (queue_item)
    );

    alkd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (queue_valid),
        .item_ready (queue_ready),
        .item       (queue_item),
        .results    (results)
    );

endmodule
